// File: hdl/pftbp_pkg.sv
// -----------------------------------------------------------------------------
// pftbp_pkg
// Shared types and constants of the per-flow token bucket policer.
// -----------------------------------------------------------------------------
`default_nettype none

package pftbp_pkg;

   localparam int DEF_NUM_ENTRIES = 256;

   // Verdict codes.
   localparam logic [2:0] V_UNPOLICED = 3'd0;
   localparam logic [2:0] V_FLOW_PASS = 3'd1;
   localparam logic [2:0] V_NEW_PASS  = 3'd2;
   localparam logic [2:0] V_NON_IPV4  = 3'd3;
   localparam logic [2:0] V_OVER      = 3'd4;
   localparam logic [2:0] V_TOO_LONG  = 3'd5;
   localparam logic [2:0] V_FULL      = 3'd6;

   // Register indexes.
   localparam logic [2:0] R_WAN_PORT  = 3'd0;
   localparam logic [2:0] R_RATE      = 3'd1;
   localparam logic [2:0] R_BURST     = 3'd2;
   localparam logic [2:0] R_LIMIT     = 3'd3;
   localparam logic [2:0] R_IDLE      = 3'd4;

   localparam logic [47:0] IDLE_RESET = 48'd1000000000;

   typedef struct packed {
      logic        wan_port;
      logic [31:0] token_rate;
      logic [31:0] burst_size;
      logic [31:0] refill_limit_ns;
      logic [47:0] idle_timeout_ns;
   } pftbp_cfg_type;

   // Search record that walks down the row of cells.
   typedef struct packed {
      logic        active;
      logic        hit;
      logic [31:0] hit_level;
      logic [62:0] hit_stamp;
      logic        free;
      logic        exp;
      logic [62:0] exp_lu;
   } pftbp_rec_type;

   // Entry write broadcast to all cells.
   typedef struct packed {
      logic        en;
      logic [31:0] key;
      logic [31:0] level;
      logic [62:0] stamp;
      logic [62:0] last_use;
   } pftbp_wr_type;

endpackage

`default_nettype wire

// File: hdl/pftbp_csr.sv
// -----------------------------------------------------------------------------
// pftbp_csr
// Configuration registers behind the APB-style port.
// -----------------------------------------------------------------------------
`default_nettype none

module pftbp_csr
   import pftbp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          psel,
   input  wire logic          penable,
   input  wire logic          pwrite,
   input  wire logic [5:0]    paddr,
   input  wire logic [63:0]   pwdata,
   output logic [63:0]        prdata,
   output logic               pready,
   output pftbp_cfg_type      cfg
);

   pftbp_cfg_type cfg_ff;
   logic [2:0]    idx;
   logic          wr;

   assign idx    = paddr[5:3];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wan_port        <= 1'b0;
         cfg_ff.token_rate      <= 32'd1;
         cfg_ff.burst_size      <= 32'd1;
         cfg_ff.refill_limit_ns <= 32'd1;
         cfg_ff.idle_timeout_ns <= IDLE_RESET;
      end else if (wr) begin
         case (idx)
            R_WAN_PORT: cfg_ff.wan_port        <= pwdata[0];
            R_RATE:     cfg_ff.token_rate      <= pwdata[31:0];
            R_BURST:    cfg_ff.burst_size      <= pwdata[31:0];
            R_LIMIT:    cfg_ff.refill_limit_ns <= pwdata[31:0];
            R_IDLE:     cfg_ff.idle_timeout_ns <= pwdata[47:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         R_WAN_PORT: prdata = {63'd0, cfg_ff.wan_port};
         R_RATE:     prdata = {32'd0, cfg_ff.token_rate};
         R_BURST:    prdata = {32'd0, cfg_ff.burst_size};
         R_LIMIT:    prdata = {32'd0, cfg_ff.refill_limit_ns};
         R_IDLE:     prdata = {16'd0, cfg_ff.idle_timeout_ns};
         default:    prdata = 64'd0;
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/pftbp_cell.sv
// -----------------------------------------------------------------------------
// pftbp_cell
// One flow table entry. Checks the passing search record against its entry
// and hands the updated record to the next cell through its output register.
// -----------------------------------------------------------------------------
`default_nettype none

module pftbp_cell
   import pftbp_pkg::*;
#(
   parameter int IW       = 8,
   parameter int CELL_IDX = 0
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [31:0]   key,
   input  wire logic [62:0]   now,
   input  wire logic [47:0]   idle_timeout,
   input  wire pftbp_rec_type rec_in,
   input  wire logic [IW-1:0] hit_idx_in,
   input  wire logic [IW-1:0] free_idx_in,
   input  wire logic [IW-1:0] exp_idx_in,
   output pftbp_rec_type      rec_out,
   output logic [IW-1:0]      hit_idx_out,
   output logic [IW-1:0]      free_idx_out,
   output logic [IW-1:0]      exp_idx_out,
   input  wire pftbp_wr_type  wr,
   input  wire logic [IW-1:0] wr_idx
);

   localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

   logic          valid_ff;
   logic [31:0]   key_ff;
   logic [31:0]   level_ff;
   logic [62:0]   stamp_ff;
   logic [62:0]   lu_ff;

   pftbp_rec_type rec_ff, rec_in_c;
   logic [IW-1:0] hit_idx_ff, free_idx_ff, exp_idx_ff;
   logic [IW-1:0] hit_idx_in_c, free_idx_in_c, exp_idx_in_c;
   logic [62:0]   idle;
   logic          take_hit, take_free, take_exp;

   always_comb begin
      idle      = (now >= lu_ff) ? (now - lu_ff) : 63'd0;
      take_hit  = valid_ff && (key_ff == key) && !rec_in.hit;
      take_free = !valid_ff && !rec_in.free;
      // Strict compare keeps the lower index on equal last use.
      take_exp  = (idle >= 63'(idle_timeout)) && (!rec_in.exp || (lu_ff < rec_in.exp_lu));

      rec_in_c      = rec_in;
      hit_idx_in_c  = hit_idx_in;
      free_idx_in_c = free_idx_in;
      exp_idx_in_c  = exp_idx_in;
      if (take_hit) begin
         rec_in_c.hit       = 1'b1;
         rec_in_c.hit_level = level_ff;
         rec_in_c.hit_stamp = stamp_ff;
         hit_idx_in_c       = MY_IDX;
      end
      if (take_free) begin
         rec_in_c.free = 1'b1;
         free_idx_in_c = MY_IDX;
      end
      if (take_exp) begin
         rec_in_c.exp    = 1'b1;
         rec_in_c.exp_lu = lu_ff;
         exp_idx_in_c    = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.active <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         rec_ff.active <= rec_in.active;
         if (wr.en && (wr_idx == MY_IDX)) begin
            valid_ff <= 1'b1;
         end
      end
      rec_ff.hit       <= rec_in_c.hit;
      rec_ff.hit_level <= rec_in_c.hit_level;
      rec_ff.hit_stamp <= rec_in_c.hit_stamp;
      rec_ff.free      <= rec_in_c.free;
      rec_ff.exp       <= rec_in_c.exp;
      rec_ff.exp_lu    <= rec_in_c.exp_lu;
      hit_idx_ff       <= hit_idx_in_c;
      free_idx_ff      <= free_idx_in_c;
      exp_idx_ff       <= exp_idx_in_c;
      if (wr.en && (wr_idx == MY_IDX)) begin
         key_ff   <= wr.key;
         level_ff <= wr.level;
         stamp_ff <= wr.stamp;
         lu_ff    <= wr.last_use;
      end
   end

   assign rec_out      = rec_ff;
   assign hit_idx_out  = hit_idx_ff;
   assign free_idx_out = free_idx_ff;
   assign exp_idx_out  = exp_idx_ff;

endmodule

`default_nettype wire

// File: hdl/per_flow_token_bucket_policer.sv
// -----------------------------------------------------------------------------
// per_flow_token_bucket_policer
// Polices WAN packets per IPv4 destination with a token bucket per flow.
// -----------------------------------------------------------------------------
// A packet descriptor is taken on the req_ channel (valid/ready) and one
// verdict comes back on the rsp_ channel. The block works on one transaction
// at a time: req_ready is high only while no transaction is in progress.
// Non-IPv4 and unpoliced packets go from acceptance straight to the EMIT
// state. A policed packet sends a search record down the row of NUM_ENTRIES
// flow cells, one cell per cycle; the search result is captured at the end
// of the row, the refill arithmetic runs through the ELAP, MULT and SUM
// states, and the verdict is then loaded into the output register from the
// EMIT state. The entry update is written when the verdict is loaded into
// the output register, and the next request can be accepted in the cycle
// after that. The output register holds a verdict until rsp_ready takes
// it; a new request is accepted meanwhile, and its verdict waits until the
// register is free. Reset empties the flow table and loads the register
// defaults. The user must write configuration over the APB-style port only
// while the block is idle; the block itself does not enforce this.
// -----------------------------------------------------------------------------
`default_nettype none

module per_flow_token_bucket_policer
   import pftbp_pkg::*;
#(
   parameter int NUM_ENTRIES = DEF_NUM_ENTRIES
)
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic          req_from_port,
   input  wire logic          req_is_ipv4,
   input  wire logic [31:0]   req_dest_ip,
   input  wire logic [15:0]   req_packet_length,
   input  wire logic [62:0]   req_now_ns,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [2:0]         rsp_verdict,
   output logic               rsp_forward,
   output logic               rsp_out_port,
   input  wire logic          psel,
   input  wire logic          penable,
   input  wire logic          pwrite,
   input  wire logic [5:0]    paddr,
   input  wire logic [63:0]   pwdata,
   output logic [63:0]        prdata,
   output logic               pready
);

   localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_ELAP = 3'd2;
   localparam logic [2:0] ST_MULT = 3'd3;
   localparam logic [2:0] ST_SUM  = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   pftbp_cfg_type cfg;

   pftbp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   logic [2:0]    state_ff, state_in;
   logic          launch_ff;
   logic          port_ff, ipv4_ff;
   logic [31:0]   key_ff;
   logic [15:0]   len_ff;
   logic [62:0]   now_ff;

   logic          hit_ff, free_ff, exp_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff, exp_idx_ff;
   logic [31:0]   lvl_ff;
   logic [62:0]   stamp_ff;
   logic [62:0]   elapsed_ff;
   logic          lim_ok_ff;
   logic [63:0]   prod_ff;
   logic [64:0]   sum;

   logic          rsp_valid_ff;
   logic [2:0]    verdict_ff, verdict_c;
   logic          forward_ff, forward_c;
   logic          out_port_ff;
   logic          out_free, accept, emit;

   pftbp_wr_type  wr;
   logic [IW-1:0] wr_idx;
   logic          do_write;

   pftbp_rec_type rec      [NUM_ENTRIES+1];
   logic [IW-1:0] hit_idx  [NUM_ENTRIES+1];
   logic [IW-1:0] free_idx [NUM_ENTRIES+1];
   logic [IW-1:0] exp_idx  [NUM_ENTRIES+1];

   assign accept   = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = (state_ff == ST_EMIT) && out_free;

   always_comb begin
      rec[0]        = '0;
      rec[0].active = launch_ff;
      hit_idx[0]    = '0;
      free_idx[0]   = '0;
      exp_idx[0]    = '0;
   end

   for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
      pftbp_cell #(
         .IW       (IW),
         .CELL_IDX (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .key          (key_ff),
         .now          (now_ff),
         .idle_timeout (cfg.idle_timeout_ns),
         .rec_in       (rec[g]),
         .hit_idx_in   (hit_idx[g]),
         .free_idx_in  (free_idx[g]),
         .exp_idx_in   (exp_idx[g]),
         .rec_out      (rec[g+1]),
         .hit_idx_out  (hit_idx[g+1]),
         .free_idx_out (free_idx[g+1]),
         .exp_idx_out  (exp_idx[g+1]),
         .wr           (wr),
         .wr_idx       (wr_idx)
      );
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_is_ipv4 && (req_from_port == cfg.wan_port)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_SCAN: if (rec[NUM_ENTRIES].active) state_in = ST_ELAP;
         ST_ELAP: state_in = ST_MULT;
         ST_MULT: state_in = ST_SUM;
         ST_SUM:  state_in = ST_EMIT;
         ST_EMIT: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign sum = {1'b0, prod_ff} + 65'(lvl_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         launch_ff <= accept && req_is_ipv4 && (req_from_port == cfg.wan_port);
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (accept) begin
         port_ff <= req_from_port;
         ipv4_ff <= req_is_ipv4;
         key_ff  <= req_dest_ip;
         len_ff  <= req_packet_length;
         now_ff  <= req_now_ns;
      end
      if ((state_ff == ST_SCAN) && rec[NUM_ENTRIES].active) begin
         hit_ff      <= rec[NUM_ENTRIES].hit;
         free_ff     <= rec[NUM_ENTRIES].free;
         exp_ff      <= rec[NUM_ENTRIES].exp;
         lvl_ff      <= rec[NUM_ENTRIES].hit_level;
         stamp_ff    <= rec[NUM_ENTRIES].hit_stamp;
         hit_idx_ff  <= hit_idx[NUM_ENTRIES];
         free_idx_ff <= free_idx[NUM_ENTRIES];
         exp_idx_ff  <= exp_idx[NUM_ENTRIES];
      end
      if (state_ff == ST_ELAP) begin
         elapsed_ff <= (now_ff >= stamp_ff) ? (now_ff - stamp_ff) : 63'd0;
      end
      if (state_ff == ST_MULT) begin
         lim_ok_ff <= elapsed_ff < 63'(cfg.refill_limit_ns);
         prod_ff   <= 64'(elapsed_ff[31:0]) * 64'(cfg.token_rate);
      end
      if (state_ff == ST_SUM) begin
         // Past the refill limit, or a refill over capacity, fills the bucket.
         if (!lim_ok_ff || (sum > 65'(cfg.burst_size))) begin
            lvl_ff <= cfg.burst_size;
         end else begin
            lvl_ff <= sum[31:0];
         end
      end
      if (emit) begin
         verdict_ff  <= verdict_c;
         forward_ff  <= forward_c;
         out_port_ff <= forward_c ? !port_ff : 1'b0;
      end
   end

   always_comb begin
      verdict_c   = V_FULL;
      forward_c   = 1'b0;
      do_write    = 1'b0;
      wr_idx      = hit_idx_ff;
      wr.key      = key_ff;
      wr.stamp    = now_ff;
      wr.last_use = now_ff;
      wr.level    = lvl_ff;
      if (!ipv4_ff) begin
         verdict_c = V_NON_IPV4;
      end else if (port_ff != cfg.wan_port) begin
         verdict_c = V_UNPOLICED;
         forward_c = 1'b1;
      end else if (hit_ff) begin
         do_write = 1'b1;
         if (lvl_ff > 32'(len_ff)) begin
            verdict_c = V_FLOW_PASS;
            forward_c = 1'b1;
            wr.level  = lvl_ff - 32'(len_ff);
         end else begin
            verdict_c = V_OVER;
         end
      end else if (32'(len_ff) > cfg.burst_size) begin
         verdict_c = V_TOO_LONG;
      end else if (free_ff || exp_ff) begin
         do_write  = 1'b1;
         verdict_c = V_NEW_PASS;
         forward_c = 1'b1;
         wr_idx    = free_ff ? free_idx_ff : exp_idx_ff;
         wr.level  = cfg.burst_size - 32'(len_ff);
      end
      wr.en = emit && do_write;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_verdict  = verdict_ff;
   assign rsp_forward  = forward_ff;
   assign rsp_out_port = out_port_ff;

endmodule

`default_nettype wire

// File: test/tb_per_flow_token_bucket_policer.sv
// -----------------------------------------------------------------------------
// tb_per_flow_token_bucket_policer
// Drives packet descriptors with random gaps and stalls, predicts each verdict
// from a flow-table model of the policer and compares it field by field.
// -----------------------------------------------------------------------------
`default_nettype none

module tb_per_flow_token_bucket_policer;
   import pftbp_pkg::*;

   localparam int FLOWS = DEF_NUM_ENTRIES;

   typedef struct packed {
      logic [2:0] verdict;
      logic       forward;
      logic       out_port;
   } verdict_type;

   typedef struct {
      logic        from_port;
      logic        is_ipv4;
      logic [31:0] dest_ip;
      logic [15:0] len;
      logic [62:0] now_ns;
      logic        known;     // expected result typed in below
      verdict_type want;
   } pkt_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_from_port = 1'b0;
   logic        req_is_ipv4 = 1'b0;
   logic [31:0] req_dest_ip = '0;
   logic [15:0] req_packet_length = '0;
   logic [62:0] req_now_ns = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_verdict;
   logic        rsp_forward;
   logic        rsp_out_port;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [5:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   per_flow_token_bucket_policer u_top (.*);

   always #5 clock = ~clock;

   // Policer model state.
   pftbp_cfg_type cfg;
   logic          fl_valid [FLOWS];
   logic [31:0]   fl_key [FLOWS];
   logic [31:0]   fl_level [FLOWS];
   logic [62:0]   fl_stamp [FLOWS];
   logic [62:0]   fl_last [FLOWS];

   verdict_type pending_verdicts[$];
   int          errors = 0;
   bit          long_stalls = 1'b0;

   function automatic logic [63:0] since(logic [62:0] now, logic [62:0] then);
      return (now >= then) ? 64'(now - then) : 64'd0;
   endfunction

   function automatic verdict_type police(pkt_type p);
      verdict_type v;
      int          hit;
      int          slot;
      logic [63:0] elapsed;
      logic [63:0] lvl;
      logic [63:0] add;
      hit = -1;
      slot = -1;
      v = '{V_NON_IPV4, 1'b0, 1'b0};
      if (!p.is_ipv4) return v;
      if (p.from_port != cfg.wan_port) return '{V_UNPOLICED, 1'b1, ~p.from_port};
      for (int i = 0; i < FLOWS; i++)
         if (hit < 0 && fl_valid[i] && fl_key[i] == p.dest_ip) hit = i;
      if (hit >= 0) begin
         elapsed = since(p.now_ns, fl_stamp[hit]);
         lvl = fl_level[hit];
         fl_last[hit] = p.now_ns;
         if (elapsed < cfg.refill_limit_ns) begin
            add = elapsed * cfg.token_rate;
            if (add > ~lvl) lvl = cfg.burst_size;
            else begin
               lvl += add;
               if (lvl > cfg.burst_size) lvl = cfg.burst_size;
            end
         end else begin
            lvl = cfg.burst_size;
         end
         fl_stamp[hit] = p.now_ns;
         if (lvl > p.len) begin
            fl_level[hit] = 32'(lvl - p.len);
            return '{V_FLOW_PASS, 1'b1, ~p.from_port};
         end
         fl_level[hit] = lvl[31:0];
         return '{V_OVER, 1'b0, 1'b0};
      end
      if (p.len > cfg.burst_size) return '{V_TOO_LONG, 1'b0, 1'b0};
      for (int i = 0; i < FLOWS; i++)
         if (slot < 0 && !fl_valid[i]) slot = i;
      if (slot < 0)
         for (int i = 0; i < FLOWS; i++)
            if (since(p.now_ns, fl_last[i]) >= cfg.idle_timeout_ns)
               if (slot < 0 || fl_last[i] < fl_last[slot]) slot = i;
      if (slot < 0) return '{V_FULL, 1'b0, 1'b0};
      fl_valid[slot] = 1'b1;
      fl_key[slot] = p.dest_ip;
      fl_level[slot] = cfg.burst_size - 32'(p.len);
      fl_stamp[slot] = p.now_ns;
      fl_last[slot] = p.now_ns;
      return '{V_NEW_PASS, 1'b1, ~p.from_port};
   endfunction

   function automatic int gap_len(bit allow_long);
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 0;
      if (r < 90 || !allow_long) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [63:0] val);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 6'(idx) << 3;
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         R_WAN_PORT: cfg.wan_port = val[0];
         R_RATE:     cfg.token_rate = val[31:0];
         R_BURST:    cfg.burst_size = val[31:0];
         R_LIMIT:    cfg.refill_limit_ns = val[31:0];
         R_IDLE:     cfg.idle_timeout_ns = val[47:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Waits for all verdicts, then for the longest search plus margin.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (FLOWS + 20) @(posedge clock);
   endtask

   task automatic send(pkt_type p);
      verdict_type v;
      int          gap;
      v = police(p);
      if (p.known && v !== p.want) begin
         $error("directed row: verdict expected %0d actual model %0d",
                p.want.verdict, v.verdict);
         errors++;
      end
      req_from_port <= p.from_port;
      req_is_ipv4 <= p.is_ipv4;
      req_dest_ip <= p.dest_ip;
      req_packet_length <= p.len;
      req_now_ns <= p.now_ns;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_verdicts.push_back(v);
      // Without a gap, valid stays high and the next call puts up a new payload.
      gap = gap_len(1'b1);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic pkt_type mk(logic fp, logic v4, logic [31:0] a, logic [15:0] l,
                                  logic [62:0] t, logic k, logic [2:0] vd, logic fw,
                                  logic op);
      pkt_type p;
      p = '{fp, v4, a, l, t, k, '{vd, fw, op}};
      return p;
   endfunction

   // Result checker.
   always @(posedge clock) begin
      verdict_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected transaction: verdict %0d", rsp_verdict);
            errors++;
         end else begin
            w = pending_verdicts.pop_front();
            if (rsp_verdict !== w.verdict) begin
               $error("verdict expected %0d actual %0d", w.verdict, rsp_verdict);
               errors++;
            end
            if (rsp_forward !== w.forward) begin
               $error("forward expected %0d actual %0d", w.forward, rsp_forward);
               errors++;
            end
            if (rsp_out_port !== w.out_port) begin
               $error("out_port expected %0d actual %0d", w.out_port, rsp_out_port);
               errors++;
            end
         end
      end
   end

   // Receiver stall pattern; long stalls only in some phases.
   initial begin
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         rsp_ready <= 1'b0;
         repeat (gap_len(long_stalls) + 1) @(posedge clock);
      end
   end

   initial begin
      #40000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      pkt_type     table_rows[$];
      pkt_type     p;
      logic [31:0] keys[16];
      logic [62:0] tnow;
      int          phase;
      cfg = '{1'b0, 32'd1, 32'd1, 32'd1, IDLE_RESET};
      for (int i = 0; i < FLOWS; i++) fl_valid[i] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows under reset settings (wan_port 0, burst 1).
      table_rows.push_back(mk(0, 0, 32'h0, 16'h0, 63'd0, 1, V_NON_IPV4, 0, 0));
      table_rows.push_back(mk(1, 0, '1, '1, '1, 1, V_NON_IPV4, 0, 0));
      table_rows.push_back(mk(1, 1, '1, '1, 63'd5, 1, V_UNPOLICED, 1, 0));
      table_rows.push_back(mk(0, 1, 32'h0A000001, 16'd2, 63'd10, 1, V_TOO_LONG, 0, 0));
      table_rows.push_back(mk(0, 1, 32'h0A000001, 16'd0, 63'd10, 1, V_NEW_PASS, 1, 1));
      table_rows.push_back(mk(0, 1, 32'h0A000001, 16'd0, 63'd10, 1, V_FLOW_PASS, 1, 1));
      table_rows.push_back(mk(0, 1, 32'h0A000001, 16'd0, 63'd20, 1, V_FLOW_PASS, 1, 1));
      table_rows.push_back(mk(0, 1, 32'hFFFFFFFF, 16'd1, 63'd30, 1, V_NEW_PASS, 1, 1));
      table_rows.push_back(mk(0, 1, 32'h0, 16'd0, 63'd25, 0, '0, 0, 0));
      table_rows.push_back(mk(0, 1, 32'h0, 16'd0, 63'd3, 0, '0, 0, 0));
      foreach (table_rows[i]) send(table_rows[i]);
      drain();

      // Large buckets; huge refill, time going backwards, burst lowered later.
      csr_write(R_RATE, 64'hFFFFFFFF);
      csr_write(R_BURST, 64'hFFFFFFFF);
      csr_write(R_LIMIT, 64'hFFFFFFFF);
      csr_write(R_IDLE, 64'hFFFF_FFFF_FFFF);
      table_rows.delete();
      table_rows.push_back(mk(0, 1, 32'h1, 16'hFFFF, 63'd100, 1, V_NEW_PASS, 1, 1));
      table_rows.push_back(mk(0, 1, 32'h1, 16'hFFFF, 63'd50, 0, '0, 0, 0));
      table_rows.push_back(mk(0, 1, 32'h1, 16'd7, 63'h7FFF_FFFF_0000_0000, 0, '0, 0, 0));
      table_rows.push_back(mk(0, 1, 32'h1, 16'd7, '1, 0, '0, 0, 0));
      foreach (table_rows[i]) send(table_rows[i]);
      drain();
      csr_write(R_BURST, 64'd1000);
      csr_write(R_RATE, 64'd0);
      csr_write(R_LIMIT, 64'd0);
      send(mk(0, 1, 32'h1, 16'd10, '1, 0, '0, 0, 0));
      drain();
      csr_write(R_WAN_PORT, 64'd1);
      send(mk(1, 1, 32'h1, 16'd10, '1, 0, '0, 0, 0));
      send(mk(0, 1, 32'h1, 16'd10, '1, 1, V_UNPOLICED, 1, 1));
      drain();

      // Random phases; time restarts low but flows keep their stamps.
      tnow = 63'd1000;
      for (phase = 0; phase < 6; phase++) begin
         long_stalls = phase[0];
         csr_write(R_WAN_PORT, 64'($urandom_range(0, 1)));
         csr_write(R_RATE, (phase == 5) ? 64'hFFFFFFFF : 64'($urandom_range(1, 50)));
         csr_write(R_BURST, (phase == 4) ? 64'hFFFFFFFF : 64'($urandom_range(200, 5000)));
         csr_write(R_LIMIT, (phase == 3) ? 64'd0 : 64'($urandom_range(10, 2000)));
         csr_write(R_IDLE, (phase == 2) ? 64'd1 : 64'($urandom_range(50, 3000)));
         foreach (keys[k]) keys[k] = $urandom();
         for (int n = 0; n < 200; n++) begin
            p.known = 1'b0;
            p.want = '0;
            p.is_ipv4 = ($urandom_range(0, 19) != 0);
            p.from_port = ($urandom_range(0, 9) == 0) ? ~cfg.wan_port : cfg.wan_port;
            // Mostly a small key set so flows are revisited; a burst of fresh
            // keys fills the table so reclaim and full-table cases occur.
            if (n >= 60 && n < 130 && phase >= 1) p.dest_ip = $urandom();
            else p.dest_ip = keys[$urandom_range(0, 15)];
            case ($urandom_range(0, 3))
               0: p.len = 16'($urandom_range(0, 65535));
               default: p.len = 16'($urandom_range(0, 300));
            endcase
            if ($urandom_range(0, 29) == 0) tnow = tnow - 63'($urandom_range(0, 20));
            else tnow = tnow + 63'($urandom_range(0, 40));
            if ($urandom_range(0, 99) == 0) tnow = 63'({$urandom(), $urandom()});
            p.now_ns = tnow;
            send(p);
            if (n == 100 && phase == 1) drain();
         end
         drain();
      end

      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire
